### sv/chs_pkg.sv
package chs_pkg;

  // Field widths fixed by the item format
  localparam int KEY_W      = 32;
  localparam int OUTCOME_W  = 2;
  localparam int COUNT_W    = 9;
  localparam int BCNT_W     = 5;
  localparam int BCNT_MAX   = (1 << BCNT_W) - 1;
  localparam logic [BCNT_W-1:0] BCNT_RESET = 5'd15;

  // APB register map
  localparam int APB_DATA_W = 32;
  localparam int REG_ADDR_W = 2;
  localparam logic [REG_ADDR_W-1:0] ADDR_BUCKET_COUNT = 2'd0;

  // Commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Result codes
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT  = 2'd0,
    OUT_MISS = 2'd1,
    OUT_FULL = 2'd2
  } outcome_e;

  // Modulo unit: bits retired per cycle and number of steps
  localparam int MOD_BITS_PER_STEP = 4;
  localparam int MOD_STEPS         = KEY_W / MOD_BITS_PER_STEP;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [KEY_W-1:0]  mag;
    logic [BCNT_W-1:0] modulus;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [BCNT_W-1:0] rem;
  } mod_rsp_t;

endpackage

### sv/chs_in_if.sv
interface chs_in_if import chs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, command, key, input ready);
  modport sink   (input valid, command, key, output ready);
endinterface

### sv/chs_out_if.sv
interface chs_out_if import chs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [COUNT_W-1:0]   stored_count;

  modport source (output valid, outcome, stored_count, input ready);
  modport sink   (input valid, outcome, stored_count, output ready);
endinterface

### sv/chs_ram.sv
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/chs_mod.sv
module chs_mod import chs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  localparam int CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  logic              busy_q, done_q, neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [KEY_W-1:0]  mag_q;
  logic [BCNT_W-1:0] rem_q, m_q;
  logic [BCNT_W-1:0] rem_d;

  // restoring remainder, MOD_BITS_PER_STEP bits per cycle; rem < m keeps each step one subtract
  always_comb begin
    logic [BCNT_W:0] part;
    part  = '0;
    rem_d = rem_q;
    for (int i = 0; i < MOD_BITS_PER_STEP; i++) begin
      part = {rem_d, mag_q[KEY_W-1-i]};
      if (part >= {1'b0, m_q}) begin
        part = part - {1'b0, m_q};
      end
      rem_d = part[BCNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      mag_q  <= '0;
      rem_q  <= '0;
      m_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        neg_q  <= req_i.neg;
        mag_q  <= req_i.mag;
        rem_q  <= '0;
        m_q    <= req_i.modulus;
      end else if (busy_q) begin
        rem_q <= rem_d;
        mag_q <= mag_q << MOD_BITS_PER_STEP;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MOD_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // fold a negative remainder back into range
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = (neg_q && rem_q != '0) ? (m_q - rem_q) : rem_q;

endmodule

### sv/chained_hash_set_core.sv
// Channel   Dir  Beat payload                 Accepted when
// item_i    in   command, key                 item_i.valid && item_i.ready
// result_o  out  outcome, stored_count        result_o.valid && result_o.ready
// APB       in   bucket_count at offset 0x0   psel && penable && pwrite (pready tied high)
//
// Per item: the remainder unit hashes the key (4 bits a cycle), S_HASH hands over the bucket,
// S_HEAD reads the head; the walk reads one node a cycle; then decide, result load in S_DONE
// and the return to S_IDLE before the next accept. An insert that stores a key also passes
// through S_LINK, which writes the tail link or, for an empty chain, the new head.
// Reset: all buckets empty, no nodes held, bucket_count = 15; no clearing pass.
// item_i.ready is low while an item is in flight; a waiting result holds the current item in S_DONE.
module chained_hash_set_core import chs_pkg::*; #(
  parameter int MAX_BUCKETS = 16,
  parameter int MAX_NODES   = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  chs_in_if.sink                item_i,
  chs_out_if.source             result_o
);

  localparam int HEAD_DEPTH = (MAX_BUCKETS < BCNT_MAX) ? MAX_BUCKETS : BCNT_MAX;
  localparam int BKT_W      = (HEAD_DEPTH > 1) ? $clog2(HEAD_DEPTH) : 1;
  localparam int PTR_W      = $clog2(MAX_NODES + 1);
  localparam int IDX_W      = $clog2(MAX_NODES);
  localparam int NODE_W     = KEY_W + PTR_W;
  localparam logic [PTR_W-1:0] NO_NODE = PTR_W'(MAX_NODES);

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_HEAD, S_WALK, S_DECIDE, S_LINK, S_DONE
  } state_e;

  state_e            state_q;
  logic              cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [BKT_W-1:0]  bkt_q;
  logic [IDX_W-1:0]  cur_q, tail_q;
  logic [KEY_W-1:0]  tail_key_q;
  logic              tail_vld_q, found_q;
  logic [PTR_W-1:0]  cnt_q;
  logic [PTR_W-1:0]  head_q [HEAD_DEPTH];
  logic [HEAD_DEPTH-1:0] head_vld_q;
  logic [BCNT_W-1:0] bcount_q;
  outcome_e          outcome_q;
  logic              out_vld_q;
  logic [OUTCOME_W-1:0] out_outcome_q;
  logic [COUNT_W-1:0]   out_count_q;

  logic              item_acc, cfg_wr;
  logic [BCNT_W-1:0] eff_bcount;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [NODE_W-1:0] ram_wdata, ram_rdata;
  logic [KEY_W-1:0]  node_key;
  logic [PTR_W-1:0]  node_link;
  logic              node_hit, store_full;

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_BUCKET_COUNT);
  assign prdata = (paddr == ADDR_BUCKET_COUNT) ? APB_DATA_W'(bcount_q) : '0;

  // clamp bucket count to 1 .. HEAD_DEPTH (MAX_BUCKETS capped at BCNT_MAX)
  always_comb begin
    if (bcount_q == '0) begin
      eff_bcount = BCNT_W'(1);
    end else if (32'(bcount_q) > MAX_BUCKETS) begin
      eff_bcount = BCNT_W'(HEAD_DEPTH);
    end else begin
      eff_bcount = bcount_q;
    end
  end

  assign item_i.ready = (state_q == S_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;

  // remainder unit
  assign mod_req.start   = item_acc;
  assign mod_req.neg     = item_i.key[KEY_W-1];
  assign mod_req.mag     = item_i.key[KEY_W-1] ? (~item_i.key + 1'b1) : item_i.key;
  assign mod_req.modulus = eff_bcount;

  chs_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // node store: {key, link}
  assign node_key   = ram_rdata[NODE_W-1:PTR_W];
  assign node_link  = ram_rdata[PTR_W-1:0];
  assign node_hit   = (node_key == key_q);
  assign store_full = (cnt_q == NO_NODE);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = node_link[IDX_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = cnt_q[IDX_W-1:0];
    ram_wdata = {key_q, NO_NODE};
    case (state_q)
      S_HEAD: begin
        ram_re    = head_vld_q[bkt_q];
        ram_raddr = head_q[bkt_q][IDX_W-1:0];
      end
      S_WALK: begin
        ram_re = !node_hit && (node_link != NO_NODE);
      end
      S_DECIDE: begin
        ram_we = (cmd_q == CMD_INSERT) && !found_q && !store_full;
      end
      S_LINK: begin
        ram_we    = tail_vld_q;
        ram_waddr = tail_q;
        ram_wdata = {tail_key_q, cnt_q};
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  chs_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer, bucket heads and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cmd_q         <= CMD_INSERT;
      key_q         <= '0;
      bkt_q         <= '0;
      cur_q         <= '0;
      tail_q        <= '0;
      tail_key_q    <= '0;
      tail_vld_q    <= 1'b0;
      found_q       <= 1'b0;
      cnt_q         <= '0;
      head_vld_q    <= '0;
      bcount_q      <= BCNT_RESET;
      outcome_q     <= OUT_HIT;
      out_vld_q     <= 1'b0;
      out_outcome_q <= '0;
      out_count_q   <= '0;
      for (int i = 0; i < HEAD_DEPTH; i++) begin
        head_q[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        bcount_q <= pwdata[BCNT_W-1:0];
      end
      // a taken beat frees the result register; S_DONE loads it on its own
      if (result_o.ready && state_q != S_DONE) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (item_acc) begin
            cmd_q      <= item_i.command;
            key_q      <= item_i.key;
            tail_vld_q <= 1'b0;
            found_q    <= 1'b0;
            state_q    <= S_HASH;
          end
        end
        S_HASH: begin
          if (mod_rsp.done) begin
            bkt_q   <= mod_rsp.rem[BKT_W-1:0];
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          cur_q   <= head_q[bkt_q][IDX_W-1:0];
          state_q <= head_vld_q[bkt_q] ? S_WALK : S_DECIDE;
        end
        S_WALK: begin
          if (node_hit) begin
            found_q <= 1'b1;
            state_q <= S_DECIDE;
          end else begin
            tail_q     <= cur_q;
            tail_key_q <= node_key;
            tail_vld_q <= 1'b1;
            cur_q      <= node_link[IDX_W-1:0];
            if (node_link == NO_NODE) begin
              state_q <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (cmd_q == CMD_SEARCH) begin
            outcome_q <= found_q ? OUT_HIT : OUT_MISS;
            state_q   <= S_DONE;
          end else if (found_q) begin
            outcome_q <= OUT_MISS;
            state_q   <= S_DONE;
          end else if (store_full) begin
            outcome_q <= OUT_FULL;
            state_q   <= S_DONE;
          end else begin
            outcome_q <= OUT_HIT;
            state_q   <= S_LINK;
          end
        end
        S_LINK: begin
          // empty chain: the new node becomes the head
          if (!tail_vld_q) begin
            head_q[bkt_q]     <= cnt_q;
            head_vld_q[bkt_q] <= 1'b1;
          end
          cnt_q   <= cnt_q + 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_vld_q || result_o.ready) begin
            out_vld_q     <= 1'b1;
            out_outcome_q <= outcome_q;
            out_count_q   <= COUNT_W'(cnt_q);
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.outcome      = out_outcome_q;
  assign result_o.stored_count = out_count_q;

endmodule

### sv/chs_checker.sv
module chs_checker import chs_pkg::*; #(
  parameter int MAX_NODES = 256
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [OUTCOME_W-1:0] outcome_i,
  input logic [COUNT_W-1:0]   stored_count_i
);

  // one item in flight: no new beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("item accepted while previous item still in flight");

  // a fresh result follows a cycle where the input side was busy
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without item processing");

  // full is reported only with the store at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && outcome_i == OUT_FULL) |-> (stored_count_i == COUNT_W'(MAX_NODES)))
    else $error("full reported below capacity");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(outcome_i) && $stable(stored_count_i)))
    else $error("stalled result beat changed");

endmodule

bind chained_hash_set_core chs_checker #(
  .MAX_NODES (MAX_NODES)
) u_chs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (item_i.valid),
  .in_ready_i     (item_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .outcome_i      (result_o.outcome),
  .stored_count_i (result_o.stored_count)
);
